// ===== sv/hgci_pkg.sv =====
`timescale 1ns / 1ps
// hgci_pkg: shared types, constants and digit helpers for the hex grid child iterator
// no dependencies; imported by every other file of the block

package hgci_pkg;

  localparam int unsigned CELL_W          = 64;
  localparam int unsigned RES_W           = 4;
  localparam int unsigned DIGIT_W         = 3;
  localparam int unsigned SHIFT_W         = 6;
  localparam int unsigned NUM_DIGITS      = 16;
  localparam int unsigned MAX_RES         = 15;
  localparam int unsigned RES_FIELD_SHIFT = 52;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 3'd7;
  localparam logic [DIGIT_W-1:0] DIGIT_SKIP = 3'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_TOP  = 6'd45;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [CELL_W-1:0] idx;
  } res_t;

  // bit position of the digit of resolution r
  function automatic logic [SHIFT_W-1:0] digit_shift(logic [RES_W-1:0] r);
    logic [SHIFT_W-1:0] r3;
    r3 = {2'b00, r} + {1'b0, r, 1'b0};
    return SHIFT_TOP - r3;
  endfunction

endpackage

// ===== sv/hgci_in_if.sv =====
`timescale 1ns / 1ps
// hgci_in_if: input channel carrying start and step transactions
// depends on hgci_pkg

interface hgci_in_if import hgci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CELL_W-1:0] parent_index;
  logic [RES_W-1:0]  child_res;
  logic              parent_is_pentagon;

  modport source (output valid, output op, output parent_index, output child_res,
                  output parent_is_pentagon, input ready);
  modport sink   (input valid, input op, input parent_index, input child_res,
                  input parent_is_pentagon, output ready);
endinterface

// ===== sv/hgci_out_if.sv =====
`timescale 1ns / 1ps
// hgci_out_if: output channel carrying the current child index
// depends on hgci_pkg

interface hgci_out_if import hgci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] child_index;
  logic              done_res;

  modport source (output valid, output child_index, output done_res, input ready);
  modport sink   (input valid, input child_index, input done_res, output ready);
endinterface

// ===== sv/hex_grid_child_iterator.sv =====
`timescale 1ns / 1ps
// hex_grid_child_iterator: top level, sequencer plus output register
// depends on hgci_pkg, hgci_in_if, hgci_out_if and hgci_ctrl
//
//   channel  dir  transaction
//   in_i     in   op, parent_index, child_res, parent_is_pentagon
//   out_o    out  child_index, done_res
//
// start: the sequencer builds the first child, then the result is handed over
// step: a null index is handed over as it is; otherwise the child digit add, then
//   the carry walk visits one digit after another through the shared adder, then
//   the hand over; no new transaction is accepted until the result is handed over
// reset leaves the index null; a held result in the output register does not
//   stop the next transaction, only the one after it

module hex_grid_child_iterator import hgci_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hgci_in_if.sink   in_i,
  hgci_out_if.source out_o
);

  res_t              res;
  logic              take;
  logic              out_vld_q;
  logic [CELL_W-1:0] out_cell_q;

  assign take = res.vld && (!out_vld_q || out_o.ready);

  hgci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .res_o      (res),
    .res_take_i (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_cell_q <= res.idx;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.child_index = out_cell_q;
  assign out_o.done_res    = (out_cell_q == '0);

endmodule

// ===== sv/hgci_bump.sv =====
`timescale 1ns / 1ps
// hgci_bump: shared digit unit, adds one at a digit position and reads that digit
// depends on hgci_pkg

module hgci_bump import hgci_pkg::*; (
  input  logic [CELL_W-1:0]  cell_i,
  input  logic [RES_W-1:0]   pos_i,
  output logic [CELL_W-1:0]  sum_o,
  output logic [DIGIT_W-1:0] digit_o
);

  logic [SHIFT_W-1:0] sh;
  logic [CELL_W-1:0]  sh_cell;

  assign sh      = digit_shift(pos_i);
  assign sum_o   = cell_i + (CELL_W'(1) << sh);
  assign sh_cell = cell_i >> sh;
  assign digit_o = sh_cell[DIGIT_W-1:0];

endmodule

// ===== sv/hgci_ctrl.sv =====
`timescale 1ns / 1ps
// hgci_ctrl: sequencer holding the iteration state and walking the carry one digit a cycle
// depends on hgci_pkg, hgci_in_if and hgci_bump

module hgci_ctrl import hgci_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  hgci_in_if.sink      in_i,
  output res_t         res_o,
  input  logic         res_take_i
);

  state_e             state_q, state_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic [RES_W-1:0]   par_q, par_d;
  logic [RES_W-1:0]   chd_q, chd_d;
  logic [RES_W-1:0]   pos_q, pos_d;
  logic [RES_W-1:0]   skip_q, skip_d;
  logic               skip_vld_q, skip_vld_d;
  logic               first_q, first_d;

  logic [CELL_W-1:0]  bump_sum;
  logic [DIGIT_W-1:0] bump_digit;

  logic [RES_W-1:0]   start_par;
  logic               start_bad;
  logic [CELL_W-1:0]  start_mask;
  logic [CELL_W-1:0]  start_cell;

  hgci_bump u_bump (
    .cell_i  (cell_q),
    .pos_i   (pos_q),
    .sum_o   (bump_sum),
    .digit_o (bump_digit)
  );

  // start: flag invalid requests, clear digits below the parent down to the child, rewrite resolution
  always_comb begin
    start_par = in_i.parent_index[RES_FIELD_SHIFT +: RES_W];
    start_bad = (in_i.child_res < start_par)
             || ({1'b0, in_i.child_res} > (RES_W+1)'(MAX_RES))
             || (in_i.parent_index == '0);
    start_mask = '1;
    for (int r = 0; r < NUM_DIGITS; r++) begin
      if ((RES_W'(r) > start_par) && (RES_W'(r) <= in_i.child_res)) begin
        start_mask[3*(NUM_DIGITS-1-r) +: DIGIT_W] = '0;
      end
    end
    start_cell = in_i.parent_index & start_mask;
    start_cell[RES_FIELD_SHIFT +: RES_W] = in_i.child_res;
  end

  always_comb begin
    state_d    = state_q;
    cell_d     = cell_q;
    par_d      = par_q;
    chd_d      = chd_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    skip_vld_d = skip_vld_q;
    first_d    = first_q;
    in_i.ready = (state_q == ST_IDLE);
    res_o.vld  = (state_q == ST_DONE);
    res_o.idx  = cell_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == OP_START) begin
            par_d      = start_par;
            chd_d      = in_i.child_res;
            skip_d     = in_i.child_res;
            skip_vld_d = in_i.parent_is_pentagon & ~start_bad;
            cell_d     = start_bad ? '0 : start_cell;
            state_d    = ST_DONE;
          end else if (cell_q == '0) begin
            state_d = ST_DONE;
          end else begin
            pos_d   = chd_q;
            first_d = 1'b1;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (first_q) begin
          cell_d  = bump_sum;
          first_d = 1'b0;
        end else if (pos_q == par_q) begin
          cell_d  = '0;
          state_d = ST_DONE;
        end else if (skip_vld_q && (pos_q == skip_q) && (bump_digit == DIGIT_SKIP)) begin
          cell_d  = bump_sum;
          skip_d  = skip_q - RES_W'(1);
          state_d = ST_DONE;
        end else if (bump_digit == DIGIT_MAX) begin
          cell_d = bump_sum;
          pos_d  = pos_q - RES_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cell_q     <= '0;
      par_q      <= '0;
      chd_q      <= '0;
      pos_q      <= '0;
      skip_q     <= '0;
      skip_vld_q <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cell_q     <= cell_d;
      par_q      <= par_d;
      chd_q      <= chd_d;
      pos_q      <= pos_d;
      skip_q     <= skip_d;
      skip_vld_q <= skip_vld_d;
      first_q    <= first_d;
    end
  end

endmodule

// ===== verif/tb_hex_grid_child_iterator.sv =====
`timescale 1ns / 1ps
// tb_hex_grid_child_iterator: self-checking testbench for the hex grid child iterator
// depends on hgci_pkg, hgci_in_if, hgci_out_if and hex_grid_child_iterator

module tb_hex_grid_child_iterator;
  import hgci_pkg::*;

  typedef struct {
    logic              op;
    logic [CELL_W-1:0] parent;
    logic [RES_W-1:0]  res;
    logic              penta;
    bit                drain;
  } walk_item_t;

  typedef struct {
    logic [CELL_W-1:0] idx;
    logic              done;
  } child_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 200;
  localparam int PHASE_ITEMS    = 95;

  logic clk_i = 1'b0;
  logic rst_ni;

  hgci_in_if  in_if ();
  hgci_out_if out_if ();

  hex_grid_child_iterator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [CELL_W-1:0] walk_idx;
  int                top_res;
  int                leaf_res;
  int                skip_res;

  walk_item_t  pend_q[$];
  child_t      child_q[$];
  int unsigned in_cnt;
  int unsigned out_cnt;
  int unsigned n_queued = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_cnt;
  int          errors = 0;
  int          quiet_cycles;

  function automatic logic [CELL_W-1:0] res_unit(int r);
    return 64'd1 << (3 * (15 - r));
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(logic [CELL_W-1:0] v, int r);
    logic [CELL_W-1:0] t;
    t = v >> (3 * (15 - r));
    return t[DIGIT_W-1:0];
  endfunction

  function automatic child_t next_child(walk_item_t it);
    child_t            c;
    logic [CELL_W-1:0] acc;
    int                r;
    if (it.op == OP_START) begin
      top_res  = int'(it.parent[RES_FIELD_SHIFT +: RES_W]);
      leaf_res = int'(it.res);
      skip_res = -1;
      if (leaf_res < top_res || leaf_res > MAX_RES || it.parent == '0) begin
        walk_idx = '0;
      end else begin
        acc = it.parent;
        for (r = top_res + 1; r <= leaf_res; r++) acc &= ~(64'd7 << (3 * (15 - r)));
        acc[RES_FIELD_SHIFT +: RES_W] = RES_W'(leaf_res);
        walk_idx = acc;
        if (it.penta) skip_res = leaf_res;
      end
    end else if (walk_idx != '0) begin
      walk_idx += res_unit(leaf_res);
      for (r = leaf_res; r >= top_res; r--) begin
        if (r == top_res) begin
          walk_idx = '0;
          break;
        end
        // pentagon: digit one is skipped once per position
        if (r == skip_res && digit_of(walk_idx, r) == DIGIT_SKIP) begin
          walk_idx += res_unit(r);
          skip_res--;
          break;
        end
        if (digit_of(walk_idx, r) == DIGIT_MAX) walk_idx += res_unit(r);
        else break;
      end
    end
    c.idx  = walk_idx;
    c.done = (walk_idx == '0);
    return c;
  endfunction

  function automatic logic [CELL_W-1:0] with_res(logic [CELL_W-1:0] bits, int r);
    bits[RES_FIELD_SHIFT +: RES_W] = RES_W'(r);
    return bits;
  endfunction

  function automatic walk_item_t start_item(logic [CELL_W-1:0] parent, int res, logic penta,
                                            bit drain);
    walk_item_t it;
    it.op     = OP_START;
    it.parent = parent;
    it.res    = RES_W'(res);
    it.penta  = penta;
    it.drain  = drain;
    return it;
  endfunction

  function automatic walk_item_t step_item();
    walk_item_t it;
    it.op     = OP_STEP;
    it.parent = {$urandom, $urandom};
    it.res    = RES_W'($urandom_range(15));
    it.penta  = 1'($urandom_range(1));
    it.drain  = 1'b0;
    return it;
  endfunction

  task automatic queue_item(walk_item_t it);
    pend_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_walks(int quota);
    int                added;
    int                p;
    int                span;
    int                k;
    int                steps;
    logic [CELL_W-1:0] parent;
    walk_item_t        it;
    added = 0;
    while (added < quota) begin
      if ($urandom_range(99) < 15) begin
        // noise: anything the fields allow, null parents included
        it = step_item();
        it.op = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) it.parent = '0;
        queue_item(it);
        added++;
      end else begin
        p = $urandom_range(15);
        k = $urandom_range(99);
        span = k < 15 ? 0 : k < 60 ? 1 : k < 85 ? 2 : $urandom_range(15 - p);
        if (span > 15 - p) span = 15 - p;
        parent = with_res({$urandom, $urandom}, p);
        if (parent == '0) parent[CELL_W-1] = 1'b1;
        queue_item(start_item(parent, p + span, $urandom_range(99) < 30,
                              $urandom_range(99) < 8));
        steps = span <= 1 ? $urandom_range(6, 10) :
                span == 2 ? $urandom_range(5, 55) : $urandom_range(1, 12);
        repeat (steps) queue_item(step_item());
        added += steps + 1;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || in_cnt != n_queued || out_cnt != in_cnt);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    walk_item_t it;
    if (!rst_ni) begin
      in_if.valid              <= 1'b0;
      in_if.op                 <= OP_START;
      in_if.parent_index       <= '0;
      in_if.child_res          <= '0;
      in_if.parent_is_pentagon <= 1'b0;
      in_cnt                   <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        it.op     = in_if.op;
        it.parent = in_if.parent_index;
        it.res    = in_if.child_res;
        it.penta  = in_if.parent_is_pentagon;
        it.drain  = 1'b0;
        child_q.push_back(next_child(it));
        in_cnt <= in_cnt + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pend_q[0].drain && (in_cnt != out_cnt || in_if.valid))) begin
          it = pend_q.pop_front();
          in_if.valid              <= 1'b1;
          in_if.op                 <= it.op;
          in_if.parent_index       <= it.parent;
          in_if.child_res          <= it.res;
          in_if.parent_is_pentagon <= it.penta;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    child_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_cnt      <= 0;
      hold_cnt     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_cnt <= out_cnt + 1;
        if (child_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: expected none, actual child_index=%h done_res=%b",
                   $time, out_if.child_index, out_if.done_res);
        end else begin
          want = child_q.pop_front();
          if (out_if.child_index !== want.idx) begin
            errors++;
            $display("%0t: child_index mismatch: expected %h, actual %h",
                     $time, want.idx, out_if.child_index);
          end
          if (out_if.done_res !== want.done) begin
            errors++;
            $display("%0t: done_res mismatch: expected %b, actual %b",
                     $time, want.done, out_if.done_res);
          end
        end
      end
      if (hold_cnt < hold_req) begin
        out_if.ready <= 1'b0;
        hold_cnt     <= hold_cnt + 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_hex_grid_child_iterator: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    in_if.valid              = 1'b0;
    in_if.op                 = OP_START;
    in_if.parent_index       = '0;
    in_if.child_res          = '0;
    in_if.parent_is_pentagon = 1'b0;
    out_if.ready             = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    queue_item(step_item());
    queue_item(start_item('0, 5, 1'b0, 1'b0));
    queue_item(step_item());
    queue_item(start_item(with_res({64{1'b1}}, 9), 4, 1'b0, 1'b0));
    queue_item(step_item());
    queue_item(start_item({64{1'b1}}, 15, 1'b1, 1'b0));
    queue_item(step_item());
    queue_item(start_item(with_res(64'h8000_0000_0000_0000, 0), 1, 1'b0, 1'b1));
    repeat (8) queue_item(step_item());
    queue_item(start_item(with_res(64'h0ff0_0000_0000_0000, 0), 1, 1'b1, 1'b0));
    repeat (7) queue_item(step_item());
    queue_item(start_item(with_res(64'h0000_1fff_ffff_ffff, 0), 15, 1'b1, 1'b0));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = hold_cnt + LONG_HOLD;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      queue_walks(PHASE_ITEMS);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (child_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected transactions never arrived, first child_index=%h",
               $time, child_q.size(), child_q[0].idx);
    end
    if (errors == 0) begin
      $display("tb_hex_grid_child_iterator: PASS");
    end else begin
      $display("tb_hex_grid_child_iterator: FAIL");
    end
    $finish;
  end

endmodule
